// ----- sv/signed_bcd_digit_formatter_macros.svh -----
// Assertion helpers for the checker file.
`ifndef SIGNED_BCD_DIGIT_FORMATTER_MACROS_SVH
`define SIGNED_BCD_DIGIT_FORMATTER_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define SBCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define SBCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sbcd_pkg.sv -----
`timescale 1ns / 1ps

package sbcd_pkg;

  localparam int VALUE_W = 16;
  localparam int MAG_W   = 14;
  localparam int NDIG    = 4;
  localparam int BCD_W   = 4 * NDIG;
  localparam int CODE_W  = 4;
  localparam int POS_W   = 3;
  // each double-dabble stage shifts in half of the magnitude bits
  localparam int STEPS   = MAG_W / 2;

  localparam logic [VALUE_W-2:0]        MAX_POS = 15'd9999;
  localparam logic signed [VALUE_W-1:0] MIN_NEG = -16'sd999;
  localparam logic [CODE_W-1:0]         CODE_RESET = 4'hF;

  // register index decoded from paddr[2]
  localparam logic REG_BLANK = 1'b0;
  localparam logic REG_SIGN  = 1'b1;

  typedef struct packed {
    logic             ok;   // value lies in the displayable range
    logic             neg;  // negative, sign code goes on top
    logic [MAG_W-1:0] mag;  // magnitude bits not yet shifted into bcd
    logic [BCD_W-1:0] bcd;  // packed BCD, ones in the low nibble
  } sbcd_work_t;

  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic            b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < NDIG; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

// ----- sv/sbcd_front.sv -----
`timescale 1ns / 1ps

module sbcd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sbcd_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sbcd_pkg::sbcd_work_t                out_work
);
  import sbcd_pkg::*;

  logic       pos_ok;
  logic       neg_ok;
  sbcd_work_t work_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    pos_ok = !value[VALUE_W-1] && (value[VALUE_W-2:0] <= MAX_POS);
    neg_ok = value[VALUE_W-1] && (value >= MIN_NEG);
    work_next.ok  = pos_ok || neg_ok;
    work_next.neg = neg_ok;
    work_next.mag = neg_ok ? MAG_W'(-value) : value[MAG_W-1:0];
    work_next.bcd = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_work <= work_next;
    end
  end

endmodule

// ----- sv/sbcd_dabble.sv -----
`timescale 1ns / 1ps

module sbcd_dabble (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sbcd_pkg::sbcd_work_t in_work,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbcd_pkg::sbcd_work_t out_work
);
  import sbcd_pkg::*;

  sbcd_work_t work_next;

  assign in_ready = !out_valid || out_ready;

  // shift the top STEPS magnitude bits into the BCD accumulator
  always_comb begin
    work_next = in_work;
    for (int i = 0; i < STEPS; i++) begin
      work_next.bcd = dabble_step(work_next.bcd, work_next.mag[MAG_W-1]);
      work_next.mag = {work_next.mag[MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_work <= work_next;
    end
  end

endmodule

// ----- sv/sbcd_serial.sv -----
`timescale 1ns / 1ps

module sbcd_serial (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sbcd_pkg::sbcd_work_t         in_work,
  input  logic [sbcd_pkg::CODE_W-1:0]  blank_code,
  input  logic [sbcd_pkg::CODE_W-1:0]  sign_code,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbcd_pkg::POS_W-1:0]   out_position,
  output logic [sbcd_pkg::CODE_W-1:0]  out_code,
  output logic                         out_last
);
  import sbcd_pkg::*;

  logic [CODE_W-1:0] digit [NDIG];
  logic [CODE_W-1:0] codes_next [NDIG];
  logic [CODE_W-1:0] codes [NDIG];   // indexed by position - 1
  logic [2:0]        ndig;
  logic [1:0]        cnt;
  logic              last_beat;

  assign last_beat    = (cnt == 2'd3);
  assign out_position = {1'b0, cnt} + 3'd1;
  assign out_code     = codes[cnt];
  assign out_last     = last_beat;
  // load the next item in the same cycle the final write of this one transfers
  assign in_ready     = !out_valid || (out_ready && last_beat);

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      digit[d] = in_work.bcd[4*d +: 4];
    end
    if (digit[3] != 4'd0) begin
      ndig = 3'd4;
    end else if (digit[2] != 4'd0) begin
      ndig = 3'd3;
    end else if (digit[1] != 4'd0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
  end

  // left-aligned: position 4 takes the sign or the leading digit
  always_comb begin
    logic [2:0] idx;
    logic [2:0] off;
    idx = '0;
    off = '0;
    for (int p = 0; p < NDIG; p++) begin
      idx = 3'(NDIG - 1 - p);
      off = in_work.neg ? (idx - 3'd1) : idx;
      if (!in_work.ok) begin
        codes_next[p] = blank_code;
      end else if (in_work.neg && (idx == 3'd0)) begin
        codes_next[p] = sign_code;
      end else if (off < ndig) begin
        codes_next[p] = digit[2'(ndig - 3'd1 - off)];
      end else begin
        codes_next[p] = blank_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= 2'd0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      cnt       <= 2'd0;
    end else if (out_ready) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      codes <= codes_next;
    end
  end

endmodule

// ----- sv/signed_bcd_digit_formatter.sv -----
`timescale 1ns / 1ps
// Signed four-digit display formatter.
// Slave stream s_*: one signed 16-bit value per transfer in s_tdata.
// Master stream m_*: four digit-register writes per value, positions 1 to 4
// in order; m_tlast marks the write to position 4. Each write carries the
// position and a code (BCD digit, blank code or sign code).
// APB port: register 0 (addr 0x0) blank code, register 1 (addr 0x4) sign
// code, both 4 bits, reset to 0xF. Write them only while the block is idle.
// Path: the range check, the two double-dabble stages and the output
// register are each registered, in that order. The output register gives
// one write per cycle while m_tready is high and takes a new value only
// with the last write of the one before; the pipeline itself takes a value
// every cycle unless stalled and buffers up to three values behind the one
// being written out.
// Reset (rst, synchronous) empties the pipeline and restores both codes.
// When m_tready is low the current write holds; once the three stages
// behind it are full, s_tready drops.
module signed_bcd_digit_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] digit_position, [6:3] digit_code, [7] zero
  output logic        m_tlast,   // last_write
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbcd_pkg::*;

  logic [CODE_W-1:0] blank_code;
  logic [CODE_W-1:0] sign_code;
  logic              reg_sel;
  logic              cfg_write;

  logic       a_valid, a_ready, b_valid, b_ready, c_valid, c_ready;
  sbcd_work_t a_work, b_work, c_work;
  logic [POS_W-1:0]  position;
  logic [CODE_W-1:0] code;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_code <= CODE_RESET;
      sign_code  <= CODE_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_BLANK: blank_code <= pwdata[CODE_W-1:0];
        REG_SIGN:  sign_code  <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BLANK: prdata = {28'd0, blank_code};
      REG_SIGN:  prdata = {28'd0, sign_code};
      default:   prdata = '0;
    endcase
  end

  sbcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .value     ($signed(s_tdata)),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_work  (a_work)
  );

  sbcd_dabble u_dabble_hi (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_work   (a_work),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_work  (b_work)
  );

  sbcd_dabble u_dabble_lo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_work   (b_work),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_work  (c_work)
  );

  sbcd_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (c_valid),
    .in_ready     (c_ready),
    .in_work      (c_work),
    .blank_code   (blank_code),
    .sign_code    (sign_code),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_position (position),
    .out_code     (code),
    .out_last     (m_tlast)
  );

  assign m_tdata = {1'b0, code, position};

endmodule

// ----- sv/sbcd_checker.sv -----
`timescale 1ns / 1ps
`include "signed_bcd_digit_formatter_macros.svh"

module sbcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled write holds its contents
  `SBCD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

  // writes of one run follow each other without a gap, position counting up
  `SBCD_ASSERT_NEXT(a_pos_step, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1), "position did not advance")

  // last marks position 4 and nothing else
  `SBCD_ASSERT_NOW(a_last_pos, clk, rst, m_tvalid, m_tlast == (m_tdata[2:0] == 3'd4), "last does not match position 4")

  // runs start at position 1 after a completed run
  `SBCD_ASSERT_NEXT(a_run_start, clk, rst, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tdata[2:0] == 3'd1), "run did not restart at position 1")

endmodule

bind signed_bcd_digit_formatter sbcd_checker u_sbcd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- dv/tb_signed_bcd_digit_formatter.sv -----
`timescale 1ns / 1ps

module tb_signed_bcd_digit_formatter;
  import sbcd_pkg::*;

  localparam int IDLE_PCT    = 14;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 8;
  localparam logic [POS_W-1:0] TOP_POS = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
    logic              last;
  } digit_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [2:0] digit_position, [6:3] digit_code, [7] zero
  logic        m_tlast;        // last_write
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  signed_bcd_digit_formatter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0]       values_to_send[$];
  digit_write_t      due_writes[$];
  logic [CODE_W-1:0] blank_now = CODE_RESET;
  logic [CODE_W-1:0] sign_now  = CODE_RESET;
  int                n_queued = 0;
  int                n_taken = 0;
  int                mismatches = 0;
  int                idle_cycles = 0;
  bit                calm = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit take_a_break();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Left-aligned layout: seq[0] lands on position 4, seq[1] on 3, and so on.
  function automatic void format_digits(input logic [15:0] raw);
    int                v;
    int                mag;
    int                len;
    int                n;
    int                idx;
    bit                shown;
    logic [CODE_W-1:0] seq[4];
    logic [CODE_W-1:0] rev[4];
    digit_write_t      w;
    v = $signed(raw);
    len = 0;
    shown = 1'b0;
    mag = 0;
    if (v >= 0 && v <= 9999) begin
      mag = v;
      shown = 1'b1;
    end else if (v < 0 && v >= -999) begin
      seq[0] = sign_now;
      len = 1;
      mag = -v;
      shown = 1'b1;
    end
    if (shown) begin
      n = 0;
      do begin
        rev[n] = CODE_W'(mag % 10);
        mag = mag / 10;
        n++;
      end while (mag != 0);
      for (int i = 0; i < n; i++) seq[len + i] = rev[n - 1 - i];
      len += n;
    end
    for (int p = 1; p <= 4; p++) begin
      idx = 4 - p;
      w.pos = POS_W'(p);
      w.code = (idx < len) ? seq[idx] : blank_now;
      w.last = (POS_W'(p) == TOP_POS);
      due_writes.push_back(w);
    end
  endfunction

  // Input side: one value per transfer, random gaps between transfers.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        format_digits(s_tdata);
        n_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (values_to_send.size() != 0 && !take_a_break()) begin
          s_tvalid <= 1'b1;
          s_tdata <= values_to_send.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each write transfer against the oldest expected one.
  always @(posedge clk) begin : mon
    digit_write_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_writes.size() == 0) begin
          flag_mismatch($sformatf("unexpected write pos=%0d code=%0h last=%0b",
                                  m_tdata[2:0], m_tdata[6:3], m_tlast));
        end else begin
          want = due_writes.pop_front();
          if (m_tdata[2:0] !== want.pos || m_tdata[6:3] !== want.code ||
              m_tdata[7] !== 1'b0 || m_tlast !== want.last) begin
            flag_mismatch($sformatf(
              "write got pos=%0d code=%0h pad=%0b last=%0b, want pos=%0d code=%0h last=%0b",
              m_tdata[2:0], m_tdata[6:3], m_tdata[7], m_tlast,
              want.pos, want.code, want.last));
          end
        end
      end
      m_tready <= !take_a_break();
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Write one code register, then read it back. Upper pwdata bits are junk.
  task automatic set_code(input logic idx, input logic [CODE_W-1:0] code);
    logic [31:0] word;
    word = $urandom;
    word[CODE_W-1:0] = code;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_BLANK) blank_now = code;
    else sign_now = code;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(32 - CODE_W){1'b0}}, code}) begin
      flag_mismatch($sformatf("reg %0d read back %0h, want %0h", idx, prdata, code));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_value(input logic [15:0] v);
    values_to_send.push_back(v);
    n_queued++;
  endtask

  // Mostly displayable values, some near the range edges, the rest anything.
  function automatic logic [15:0] pick_value();
    int edges[12] = '{0, -1, 9, 10, 99, 100, 999, 1000, 9999, 10000, -999, -1000};
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 16'($urandom_range(9999));
    if (roll < 65) return 16'(-int'($urandom_range(999, 1)));
    if (roll < 80) return 16'(edges[$urandom_range(11)] + int'($urandom_range(4)) - 2);
    return 16'($urandom);
  endfunction

  task automatic wait_drained();
    while (n_taken != n_queued || due_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) queue_value(pick_value());
    wait_drained();
  endtask

  initial begin
    int directed[22] = '{0, 5, 9, 10, 99, 100, 999, 1000, 1234, 9999, 10000, 32767,
                         -1, -9, -10, -99, -100, -507, -999, -1000, -32768, 7001};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // codes still at their reset value
    foreach (directed[i]) queue_value(16'(directed[i]));
    random_burst(60);

    set_code(REG_BLANK, 4'h0);
    set_code(REG_SIGN, 4'h0);
    random_burst(100);

    set_code(REG_BLANK, 4'hF);
    calm = 1'b1;
    random_burst(100);
    calm = 1'b0;

    set_code(REG_BLANK, 4'h0);
    set_code(REG_SIGN, 4'hF);
    random_burst(100);

    set_code(REG_BLANK, 4'($urandom));
    set_code(REG_SIGN, 4'($urandom));
    random_burst(115);

    if (due_writes.size() != 0) begin
      flag_mismatch($sformatf("%0d expected writes never arrived", due_writes.size()));
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
